>>> rtl/quadratic_probe_hash_table_macros.svh
// assertion macros used by the hash table rtl
`ifndef QUADRATIC_PROBE_HASH_TABLE_MACROS_SVH
`define QUADRATIC_PROBE_HASH_TABLE_MACROS_SVH

// same-cycle implication, quiet during reset
`define QPHT_ASSERT_NOW(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication, quiet during reset
`define QPHT_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

>>> rtl/qpht_pkg.sv
`default_nettype none

package qpht_pkg;

   // field widths
   localparam int KEY_W    = 31;
   localparam int SIZE_W   = 7;
   localparam int STATUS_W = 3;
   localparam int SLOT_W   = 6;
   localparam int OP_W     = 2;
   localparam int CNT_W    = 5;

   // table size after reset
   localparam logic [SIZE_W-1:0] SIZE_RESET = 7'd7;

   // register indexes
   localparam logic CSR_TABLE_SIZE = 1'b0;

   // request codes
   localparam logic [OP_W-1:0] OP_INSERT = 2'd0;
   localparam logic [OP_W-1:0] OP_SEARCH = 2'd1;
   localparam logic [OP_W-1:0] OP_ERASE  = 2'd2;
   localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;

   // response codes
   localparam logic [STATUS_W-1:0] ST_INSERTED  = 3'd0;
   localparam logic [STATUS_W-1:0] ST_FOUND     = 3'd1;
   localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 3'd2;
   localparam logic [STATUS_W-1:0] ST_ERASED    = 3'd3;
   localparam logic [STATUS_W-1:0] ST_FULL      = 3'd4;

   // result of the key modulo unit
   typedef struct packed {
      logic              done;
      logic [SIZE_W-1:0] rem;
   } mod_res_type;

endpackage

`default_nettype wire

>>> rtl/qpht_ram.sv
`default_nettype none

module qpht_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 64
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output      logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   // one write port, one registered read port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data <= mem_ff[rd_addr];
   end

endmodule

`default_nettype wire

>>> rtl/qpht_keymod.sv
`default_nettype none

module qpht_keymod (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          start,
   input  wire logic [qpht_pkg::KEY_W-1:0]    key,
   input  wire logic [qpht_pkg::SIZE_W-1:0]   size,
   output      qpht_pkg::mod_res_type         res
);

   logic                          busy_ff, busy_in;
   logic                          done_ff, done_in;
   logic [qpht_pkg::CNT_W-1:0]    cnt_ff, cnt_in;
   logic [qpht_pkg::SIZE_W-1:0]   rem_ff, rem_in;
   logic [qpht_pkg::SIZE_W-1:0]   div_ff, div_in;
   logic [qpht_pkg::KEY_W-1:0]    key_sh_ff, key_sh_in;
   logic [qpht_pkg::SIZE_W:0]     rem_w;
   logic [qpht_pkg::SIZE_W:0]     rem_sub;

   // restoring remainder, one key bit per cycle, msb first
   always_comb begin
      rem_w   = {rem_ff, key_sh_ff[qpht_pkg::KEY_W-1]};
      rem_sub = (rem_w >= {1'b0, div_ff}) ? rem_w - {1'b0, div_ff} : rem_w;
   end

   always_comb begin
      busy_in   = busy_ff;
      done_in   = 1'b0;
      cnt_in    = cnt_ff;
      rem_in    = rem_ff;
      div_in    = div_ff;
      key_sh_in = key_sh_ff;
      if (start) begin
         busy_in   = 1'b1;
         cnt_in    = qpht_pkg::CNT_W'(qpht_pkg::KEY_W - 1);
         rem_in    = '0;
         div_in    = size;
         key_sh_in = key;
      end else if (busy_ff) begin
         rem_in    = rem_sub[qpht_pkg::SIZE_W-1:0];
         key_sh_in = {key_sh_ff[qpht_pkg::KEY_W-2:0], 1'b0};
         if (cnt_ff == '0) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end else begin
            cnt_in = cnt_ff - 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      cnt_ff    <= cnt_in;
      rem_ff    <= rem_in;
      div_ff    <= div_in;
      key_sh_ff <= key_sh_in;
   end

   assign res.done = done_ff;
   assign res.rem  = rem_ff;

endmodule

`default_nettype wire

>>> rtl/quadratic_probe_hash_table.sv
// sequence: key modulo and home slot read, then one further probed slot per cycle
//   (at most table size - 1), then the response once the response register is free
// one transaction at a time: after a request is taken, req_stall stays high until the
//   response is posted
// reset: a clearing pass writes every slot empty, with req_stall held high;
//   table_size returns to 7
`default_nettype none
`include "quadratic_probe_hash_table_macros.svh"

module quadratic_probe_hash_table #(
   parameter int SLOTS = 64
) (
   input  wire logic                             clock,
   input  wire logic                             reset,
   // request channel
   input  wire logic                             req_valid,
   output      logic                             req_stall,
   input  wire logic [qpht_pkg::OP_W-1:0]        req_type,
   input  wire logic [qpht_pkg::KEY_W-1:0]       req_key,
   // response channel
   output      logic                             rsp_valid,
   input  wire logic                             rsp_stall,
   output      logic [qpht_pkg::STATUS_W-1:0]    rsp_status,
   output      logic [qpht_pkg::SLOT_W-1:0]      rsp_slot_index,
   // register port
   input  wire logic                             csr_psel,
   input  wire logic                             csr_penable,
   input  wire logic                             csr_pwrite,
   input  wire logic [2:0]                       csr_paddr,
   input  wire logic [31:0]                      csr_pwdata,
   output      logic [31:0]                      csr_prdata,
   output      logic                             csr_pready
);

   localparam int IDX_W = $clog2(SLOTS);
   localparam int ENT_W = qpht_pkg::KEY_W + 1;
   localparam int SW    = qpht_pkg::SIZE_W;

   // controller states
   localparam logic [2:0] S_CLEAR = 3'd0;
   localparam logic [2:0] S_IDLE  = 3'd1;
   localparam logic [2:0] S_DIV   = 3'd2;
   localparam logic [2:0] S_PROBE = 3'd3;
   localparam logic [2:0] S_DONE  = 3'd4;

   logic [2:0]                          state_ff, state_in;
   logic [SW-1:0]                       size_reg_ff, size_reg_in;
   logic [SW-1:0]                       size_ff, size_in;
   logic [SW-1:0]                       size_eff;
   logic [qpht_pkg::OP_W-1:0]           op_ff, op_in;
   logic [qpht_pkg::KEY_W-1:0]          key_ff, key_in;
   logic [SW-1:0]                       probe_ff, probe_in;
   logic [SW-1:0]                       home_ff, home_in;
   logic [SW-1:0]                       sq_ff, sq_in;
   logic [SW-1:0]                       odd_ff, odd_in;
   logic [SW-1:0]                       step_ff, step_in;
   logic [qpht_pkg::STATUS_W-1:0]       status_ff, status_in;
   logic [SW-1:0]                       slot_ff, slot_in;
   logic [IDX_W-1:0]                    clr_ff, clr_in;
   logic                                rsp_valid_ff, rsp_valid_in;
   logic [qpht_pkg::STATUS_W-1:0]       rsp_status_ff, rsp_status_in;
   logic [qpht_pkg::SLOT_W-1:0]         rsp_slot_ff, rsp_slot_in;

   logic                                csr_wr;
   logic                                req_accept;
   logic                                out_free;
   logic                                mod_start;
   qpht_pkg::mod_res_type               mod_res;

   logic                                ram_we;
   logic [IDX_W-1:0]                    ram_waddr;
   logic [ENT_W-1:0]                    ram_wdata;
   logic [ENT_W-1:0]                    ram_rdata;
   logic                                rd_valid;
   logic [qpht_pkg::KEY_W-1:0]          rd_key;

   logic                                at_home, wrapped, is_ins, hit, last, fail;
   logic [SW:0]                         size8, psum, qsum, osum;
   logic [SW-1:0]                       probe_adv, sq_adv, odd_adv;

   // register port
   assign csr_pready = 1'b1;
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite && csr_pready
                       && (csr_paddr[2] == qpht_pkg::CSR_TABLE_SIZE);
   assign csr_prdata = (csr_paddr[2] == qpht_pkg::CSR_TABLE_SIZE) ? 32'(size_reg_ff) : '0;
   assign size_reg_in = csr_wr ? csr_pwdata[SW-1:0] : size_reg_ff;

   // effective size, clamped to one and to the slot count
   always_comb begin
      size_eff = size_reg_ff;
      if (size_reg_ff == '0) begin
         size_eff = SW'(1);
      end else if (32'(size_reg_ff) > SLOTS) begin
         size_eff = SW'(SLOTS);
      end
   end

   // handshakes
   assign req_stall  = (state_ff != S_IDLE);
   assign req_accept = req_valid && !req_stall;
   assign out_free   = !rsp_valid_ff || !rsp_stall;
   assign mod_start  = req_accept && (req_type != qpht_pkg::OP_UNUSED);

   qpht_keymod u_keymod (
      .clock (clock),
      .reset (reset),
      .start (mod_start),
      .key   (req_key),
      .size  (size_eff),
      .res   (mod_res)
   );

   // slot memory: valid bit above the key
   qpht_ram #(
      .WIDTH (ENT_W),
      .DEPTH (SLOTS)
   ) u_slots (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_waddr),
      .wr_data (ram_wdata),
      .rd_addr (IDX_W'(probe_in)),
      .rd_data (ram_rdata)
   );

   assign rd_valid = ram_rdata[qpht_pkg::KEY_W];
   assign rd_key   = ram_rdata[qpht_pkg::KEY_W-1:0];

   // probe evaluation on the entry read last cycle
   always_comb begin
      at_home = (step_ff == '0);
      wrapped = !at_home && (probe_ff == home_ff);
      is_ins  = (op_ff == qpht_pkg::OP_INSERT);
      if (is_ins) begin
         hit = !wrapped && !rd_valid;
      end else begin
         hit = !wrapped && rd_valid && (rd_key == key_ff);
      end
      size8 = {1'b0, size_ff};
      last  = ({1'b0, step_ff} + 1'b1) >= size8;
      fail  = !hit && (wrapped || last || (at_home && !is_ins && !rd_valid));
   end

   // next probe and next quadratic terms, each one compare and subtract
   always_comb begin
      psum      = {1'b0, probe_ff} + {1'b0, sq_ff};
      qsum      = {1'b0, sq_ff} + {1'b0, odd_ff};
      osum      = {1'b0, odd_ff} + (SW+1)'(2);
      probe_adv = (psum >= size8) ? SW'(psum - size8) : SW'(psum);
      sq_adv    = (qsum >= size8) ? SW'(qsum - size8) : SW'(qsum);
      odd_adv   = (osum >= size8) ? SW'(osum - size8) : SW'(osum);
   end

   // controller
   always_comb begin
      state_in  = state_ff;
      size_in   = size_ff;
      op_in     = op_ff;
      key_in    = key_ff;
      probe_in  = probe_ff;
      home_in   = home_ff;
      sq_in     = sq_ff;
      odd_in    = odd_ff;
      step_in   = step_ff;
      status_in = status_ff;
      slot_in   = slot_ff;
      clr_in    = clr_ff;
      ram_we    = 1'b0;
      ram_waddr = IDX_W'(probe_ff);
      ram_wdata = {1'b1, key_ff};

      rsp_valid_in  = rsp_valid_ff && rsp_stall;
      rsp_status_in = rsp_status_ff;
      rsp_slot_in   = rsp_slot_ff;

      case (state_ff)
         S_CLEAR: begin
            ram_we    = 1'b1;
            ram_waddr = clr_ff;
            ram_wdata = '0;
            clr_in    = clr_ff + 1'b1;
            if (clr_ff == IDX_W'(SLOTS - 1)) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (req_accept) begin
               op_in   = req_type;
               key_in  = req_key;
               size_in = size_eff;
               // first quadratic term 1 and first odd increment 3, modulo the size
               sq_in   = (size_eff == SW'(1)) ? '0 : SW'(1);
               case (size_eff)
                  SW'(1):  odd_in = '0;
                  SW'(2):  odd_in = SW'(1);
                  SW'(3):  odd_in = '0;
                  default: odd_in = SW'(3);
               endcase
               if (req_type == qpht_pkg::OP_UNUSED) begin
                  status_in = qpht_pkg::ST_NOT_FOUND;
                  slot_in   = '0;
                  state_in  = S_DONE;
               end else begin
                  state_in = S_DIV;
               end
            end
         end
         S_DIV: begin
            if (mod_res.done) begin
               probe_in = mod_res.rem;
               home_in  = mod_res.rem;
               step_in  = '0;
               state_in = S_PROBE;
            end
         end
         S_PROBE: begin
            if (hit) begin
               slot_in  = probe_ff;
               state_in = S_DONE;
               case (op_ff)
                  qpht_pkg::OP_INSERT: begin
                     status_in = qpht_pkg::ST_INSERTED;
                     ram_we    = 1'b1;
                  end
                  qpht_pkg::OP_ERASE: begin
                     status_in = qpht_pkg::ST_ERASED;
                     ram_we    = 1'b1;
                     ram_wdata = {1'b0, rd_key};
                  end
                  default: begin
                     status_in = qpht_pkg::ST_FOUND;
                  end
               endcase
            end else if (fail) begin
               slot_in   = '0;
               status_in = is_ins ? qpht_pkg::ST_FULL : qpht_pkg::ST_NOT_FOUND;
               state_in  = S_DONE;
            end else begin
               probe_in = probe_adv;
               sq_in    = sq_adv;
               odd_in   = odd_adv;
               step_in  = step_ff + 1'b1;
            end
         end
         S_DONE: begin
            if (out_free) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = status_ff;
               rsp_slot_in   = slot_ff[qpht_pkg::SLOT_W-1:0];
               state_in      = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         clr_ff       <= '0;
         size_reg_ff  <= qpht_pkg::SIZE_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         size_reg_ff  <= size_reg_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      size_ff       <= size_in;
      op_ff         <= op_in;
      key_ff        <= key_in;
      probe_ff      <= probe_in;
      home_ff       <= home_in;
      sq_ff         <= sq_in;
      odd_ff        <= odd_in;
      step_ff       <= step_in;
      status_ff     <= status_in;
      slot_ff       <= slot_in;
      rsp_status_ff <= rsp_status_in;
      rsp_slot_ff   <= rsp_slot_in;
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_status     = rsp_status_ff;
   assign rsp_slot_index = rsp_slot_ff;

   // checks
   `QPHT_ASSERT_NOW(a_probe_in_range, clock, reset, state_ff == S_PROBE,
      (probe_ff < size_ff) && (sq_ff < size_ff) && (odd_ff < size_ff),
      "probe or quadratic term outside the table")
   `QPHT_ASSERT_NOW(a_write_when_owned, clock, reset, ram_we,
      (state_ff == S_CLEAR) || (state_ff == S_PROBE),
      "slot memory written outside clear or probe")
   `QPHT_ASSERT_NOW(a_miss_slot_zero, clock, reset,
      rsp_valid && ((rsp_status == qpht_pkg::ST_NOT_FOUND) ||
                    (rsp_status == qpht_pkg::ST_FULL)),
      rsp_slot_index == '0, "miss response carries a slot")
   `QPHT_ASSERT_NEXT(a_done_to_probe, clock, reset,
      (state_ff == S_DIV) && mod_res.done, state_ff == S_PROBE,
      "home slot not probed after modulo")

endmodule

`default_nettype wire

>>> dv/quadratic_probe_hash_table_checker.sv
`timescale 1ns / 100ps

module quadratic_probe_hash_table_checker #(
   parameter int SLOTS = 64
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   input  logic                          req_stall,
   input  logic [qpht_pkg::OP_W-1:0]     req_type,
   input  logic [qpht_pkg::KEY_W-1:0]    req_key,
   input  logic                          rsp_valid,
   input  logic                          rsp_stall,
   input  logic [qpht_pkg::STATUS_W-1:0] rsp_status,
   input  logic [qpht_pkg::SLOT_W-1:0]   rsp_slot_index,
   input  logic                          csr_psel,
   input  logic                          csr_penable,
   input  logic                          csr_pwrite,
   input  logic [2:0]                    csr_paddr,
   input  logic [31:0]                   csr_pwdata,
   input  logic [31:0]                   csr_prdata,
   input  logic                          csr_pready,
   output int                            mismatches,
   output int                            checked,
   output int                            full_seen,
   output int                            hit_seen,
   output int                            pending
);
   import qpht_pkg::*;

   typedef struct packed {
      logic [STATUS_W-1:0] status;
      logic [SLOT_W-1:0]   slot;
   } outcome_t;

   localparam logic [2:0] SIZE_ADDR = {CSR_TABLE_SIZE, 2'b00};

   // shadow of the table and its size register
   logic [SIZE_W-1:0] size_reg;
   logic [KEY_W-1:0]  stored_key [SLOTS];
   logic              occupied   [SLOTS];
   outcome_t          outcomes_due [$];

   initial begin
      mismatches = 0;
      checked    = 0;
      full_seen  = 0;
      hit_seen   = 0;
      pending    = 0;
   end

   // size in use: zero acts as one, oversize clamps to the slot count
   function automatic int unsigned live_size();
      int unsigned s;
      s = size_reg;
      if (s == 0) s = 1;
      if (s > SLOTS) s = SLOTS;
      return s;
   endfunction

   // next slot of the quadratic probe sequence
   function automatic int unsigned next_slot(int unsigned home, int unsigned prev,
                                             int unsigned step, int unsigned size);
      if (step == 1) return (home + 1) % size;
      return (prev + (step * step) % size) % size;
   endfunction

   // work out the outcome of one transaction and update the shadow table
   task automatic resolve_request(input logic [OP_W-1:0] op, input logic [KEY_W-1:0] key);
      int unsigned size;
      int unsigned home;
      int unsigned probe;
      int unsigned hit_at;
      int unsigned i;
      logic        hit;
      logic        wrapped;
      outcome_t    res;
      size    = live_size();
      home    = key % size;
      probe   = home;
      hit     = 1'b0;
      wrapped = 1'b0;
      hit_at  = 0;
      res.status = ST_NOT_FOUND;
      res.slot   = '0;
      if (op == OP_INSERT) begin
         // home slot first, then the first empty probed slot
         if (!occupied[home]) begin
            hit    = 1'b1;
            hit_at = home;
         end else begin
            for (i = 1; i < size && !hit && !wrapped; i++) begin
               probe = next_slot(home, probe, i, size);
               if (probe == home) wrapped = 1'b1;
               else if (!occupied[probe]) begin
                  hit    = 1'b1;
                  hit_at = probe;
               end
            end
         end
         if (hit) begin
            stored_key[hit_at] = key;
            occupied[hit_at]   = 1'b1;
            res.status = ST_INSERTED;
            res.slot   = SLOT_W'(hit_at);
         end else begin
            res.status = ST_FULL;
         end
      end else if (op == OP_SEARCH || op == OP_ERASE) begin
         // empty home means not found; further on empty slots are skipped
         if (occupied[home]) begin
            if (stored_key[home] == key) begin
               hit    = 1'b1;
               hit_at = home;
            end else begin
               for (i = 1; i < size && !hit && !wrapped; i++) begin
                  probe = next_slot(home, probe, i, size);
                  if (probe == home) wrapped = 1'b1;
                  else if (occupied[probe] && stored_key[probe] == key) begin
                     hit    = 1'b1;
                     hit_at = probe;
                  end
               end
            end
         end
         if (hit) begin
            res.slot = SLOT_W'(hit_at);
            if (op == OP_ERASE) begin
               occupied[hit_at] = 1'b0;
               res.status = ST_ERASED;
            end else begin
               res.status = ST_FOUND;
            end
         end
      end
      outcomes_due.push_back(res);
   endtask

   always @(posedge clock) begin
      outcome_t due;
      if (reset) begin
         size_reg = SIZE_RESET;
         for (int n = 0; n < SLOTS; n++) occupied[n] = 1'b0;
         outcomes_due.delete();
      end else begin
         // register port: track writes, check reads
         if (csr_psel && csr_penable && csr_pready) begin
            if (csr_pwrite) begin
               if (csr_paddr == SIZE_ADDR) size_reg = csr_pwdata[SIZE_W-1:0];
            end else if (csr_paddr == SIZE_ADDR && csr_prdata !== 32'(size_reg)) begin
               $display("%0t: table_size read mismatch, expected %0d, got %0d",
                        $time, size_reg, csr_prdata);
               mismatches++;
            end
         end
         // response transaction against the oldest outcome due
         if (rsp_valid && !rsp_stall) begin
            if (outcomes_due.size() == 0) begin
               $display("%0t: unexpected response, expected none, got status %0d slot %0d",
                        $time, rsp_status, rsp_slot_index);
               mismatches++;
            end else begin
               due = outcomes_due.pop_front();
               checked++;
               if (due.status == ST_FULL) full_seen++;
               if (due.status == ST_FOUND || due.status == ST_ERASED) hit_seen++;
               if (rsp_status !== due.status) begin
                  $display("%0t: status mismatch, expected %0d, got %0d",
                           $time, due.status, rsp_status);
                  mismatches++;
               end
               if (rsp_slot_index !== due.slot) begin
                  $display("%0t: slot_index mismatch, expected %0d, got %0d",
                           $time, due.slot, rsp_slot_index);
                  mismatches++;
               end
            end
         end
         // request transaction
         if (req_valid && !req_stall) resolve_request(req_type, req_key);
      end
      pending = outcomes_due.size();
   end

endmodule

>>> dv/quadratic_probe_hash_table_test.sv
`timescale 1ns / 100ps

module quadratic_probe_hash_table_test;
   import qpht_pkg::*;

   localparam int SLOTS        = 64;
   localparam int PHASES       = 10;
   localparam int PER_PHASE    = 170;
   localparam int DRAIN_CYCLES = 120;
   localparam int IDLE_LIMIT   = 2000;

   logic                clock = 1'b0;
   logic                reset;
   logic                req_valid;
   logic                req_stall;
   logic [OP_W-1:0]     req_type;
   logic [KEY_W-1:0]    req_key;
   logic                rsp_valid;
   logic                rsp_stall;
   logic [STATUS_W-1:0] rsp_status;
   logic [SLOT_W-1:0]   rsp_slot_index;
   logic                csr_psel;
   logic                csr_penable;
   logic                csr_pwrite;
   logic [2:0]          csr_paddr;
   logic [31:0]         csr_pwdata;
   logic [31:0]         csr_prdata;
   logic                csr_pready;

   int mismatches;
   int checked;
   int full_seen;
   int hit_seen;
   int pending;
   int idle_cycles = 0;
   int stall_run = 0;
   int op_sent [4];
   int unsigned eff_size;
   logic [KEY_W-1:0] key_pool [16];

   always #10 clock = ~clock;

   quadratic_probe_hash_table #(.SLOTS(SLOTS)) dut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_type       (req_type),
      .req_key        (req_key),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_status     (rsp_status),
      .rsp_slot_index (rsp_slot_index),
      .csr_psel       (csr_psel),
      .csr_penable    (csr_penable),
      .csr_pwrite     (csr_pwrite),
      .csr_paddr      (csr_paddr),
      .csr_pwdata     (csr_pwdata),
      .csr_prdata     (csr_prdata),
      .csr_pready     (csr_pready)
   );

   quadratic_probe_hash_table_checker #(.SLOTS(SLOTS)) u_checker (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_type       (req_type),
      .req_key        (req_key),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_status     (rsp_status),
      .rsp_slot_index (rsp_slot_index),
      .csr_psel       (csr_psel),
      .csr_penable    (csr_penable),
      .csr_pwrite     (csr_pwrite),
      .csr_paddr      (csr_paddr),
      .csr_pwdata     (csr_pwdata),
      .csr_prdata     (csr_prdata),
      .csr_pready     (csr_pready),
      .mismatches     (mismatches),
      .checked        (checked),
      .full_seen      (full_seen),
      .hit_seen       (hit_seen),
      .pending        (pending)
   );

   // response stall pattern: short random runs, now and then a long quiet stretch
   always @(negedge clock) begin
      int r;
      if (stall_run == 0) begin
         r = $urandom_range(0, 9);
         if (r == 0) begin
            rsp_stall <= 1'b0;
            stall_run <= $urandom_range(100, 300);
         end else begin
            rsp_stall <= (r < 4);
            stall_run <= $urandom_range(1, 12);
         end
      end else begin
         stall_run <= stall_run - 1;
      end
   end

   // watchdog on cycles without any transaction
   always @(posedge clock) begin
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
   end

   initial begin
      wait (idle_cycles >= IDLE_LIMIT);
      $display("%0t: no transaction for %0d cycles", $time, IDLE_LIMIT);
      $display("quadratic_probe_hash_table_test failed");
      $finish;
   end

   // one request transaction, entered and left at a falling edge
   task automatic send_request(input logic [OP_W-1:0] op, input logic [KEY_W-1:0] key);
      req_valid <= 1'b1;
      req_type  <= op;
      req_key   <= key;
      do @(posedge clock); while (req_stall);
      op_sent[op]++;
      @(negedge clock);
   endtask

   // register access: setup cycle, then access cycle until pready
   task automatic csr_access(input logic write, input logic [31:0] data);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= write;
      csr_paddr   <= {CSR_TABLE_SIZE, 2'b00};
      csr_pwdata  <= data;
      @(negedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      @(negedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
   endtask

   // hold off requests until every response is back
   task automatic drain();
      req_valid <= 1'b0;
      while (pending != 0) @(negedge clock);
   endtask

   function automatic logic [31:0] phase_size(int phase);
      case (phase)
         0: return 1;
         1: return 64;
         2: return 0;
         3: return 127;
         4: return 2;
         5: return 3;
         6: return $urandom_range(8, 63);
         7: return 5;
         8: return 16;
         default: return 7;
      endcase
   endfunction

   // keys: mostly a small pool so lookups hit, some home-slot collisions, some wide
   function automatic logic [KEY_W-1:0] pick_key();
      logic [31:0] wide;
      case ($urandom_range(0, 9))
         0, 1: begin
            wide = $urandom();
            return wide[KEY_W-1:0];
         end
         2, 3: return KEY_W'($urandom_range(0, 3) + eff_size * $urandom_range(0, 1000));
         default: return key_pool[$urandom_range(0, 15)];
      endcase
   endfunction

   function automatic logic [OP_W-1:0] pick_op();
      int r;
      r = $urandom_range(0, 99);
      if (r < 40) return OP_INSERT;
      if (r < 70) return OP_SEARCH;
      if (r < 95) return OP_ERASE;
      return OP_UNUSED;
   endfunction

   initial begin
      logic [31:0] size_val;
      int sent;
      int burst;
      int gap;
      reset       = 1'b1;
      req_valid   = 1'b0;
      req_type    = OP_INSERT;
      req_key     = '0;
      rsp_stall   = 1'b0;
      csr_psel    = 1'b0;
      csr_penable = 1'b0;
      csr_pwrite  = 1'b0;
      csr_paddr   = '0;
      csr_pwdata  = '0;
      for (int n = 0; n < 4; n++) op_sent[n] = 0;
      repeat (9) @(negedge clock);
      reset <= 1'b0;

      // directed: empty table, collisions, skipping an empty probe, full table
      send_request(OP_SEARCH, 0);
      send_request(OP_ERASE, 5);
      send_request(OP_INSERT, 0);
      send_request(OP_INSERT, 7);
      send_request(OP_INSERT, 14);
      send_request(OP_SEARCH, 14);
      send_request(OP_SEARCH, 21);
      send_request(OP_ERASE, 7);
      send_request(OP_SEARCH, 14);
      send_request(OP_UNUSED, {KEY_W{1'b1}});
      send_request(OP_INSERT, {KEY_W{1'b1}});
      send_request(OP_SEARCH, {KEY_W{1'b1}});
      send_request(OP_ERASE, {KEY_W{1'b1}});
      for (int n = 0; n < 4; n++) send_request(OP_INSERT, 0);
      send_request(OP_ERASE, 0);
      send_request(OP_SEARCH, 0);
      send_request(OP_INSERT, 0);
      send_request(OP_ERASE, 14);

      // random phases, each under its own table size; contents carry over
      for (int phase = 0; phase < PHASES; phase++) begin
         drain();
         repeat (DRAIN_CYCLES) @(negedge clock);
         size_val = phase_size(phase);
         csr_access(1'b1, size_val);
         csr_access(1'b0, '0);
         eff_size = (size_val == 0) ? 1 : (size_val > SLOTS) ? SLOTS : size_val;
         for (int n = 0; n < 16; n++) key_pool[n] = KEY_W'($urandom_range(0, 3 * eff_size));
         sent = 0;
         while (sent < PER_PHASE) begin
            burst = $urandom_range(1, 24);
            for (int b = 0; b < burst && sent < PER_PHASE; b++) begin
               send_request(pick_op(), pick_key());
               sent++;
            end
            if ($urandom_range(0, 39) == 0) begin
               drain();
            end else begin
               gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10);
               if (gap != 0) begin
                  req_valid <= 1'b0;
                  repeat (gap) @(negedge clock);
               end
            end
         end
      end

      // wind down and give the verdict
      drain();
      repeat (DRAIN_CYCLES) @(negedge clock);
      $display("sent %0d insert, %0d search, %0d erase, %0d unknown over %0d table sizes",
               op_sent[OP_INSERT], op_sent[OP_SEARCH], op_sent[OP_ERASE],
               op_sent[OP_UNUSED], PHASES + 1);
      $display("checked %0d responses: %0d hits, %0d table full", checked, hit_seen, full_seen);
      if (mismatches == 0 && pending == 0) begin
         $display("quadratic_probe_hash_table_test passed");
      end else begin
         $display("quadratic_probe_hash_table_test failed");
      end
      $finish;
   end

endmodule

>>> quadratic_probe_hash_table.f
+incdir+rtl
rtl/qpht_pkg.sv
rtl/qpht_ram.sv
rtl/qpht_keymod.sv
rtl/quadratic_probe_hash_table.sv
dv/quadratic_probe_hash_table_checker.sv
dv/quadratic_probe_hash_table_test.sv
